// ----- design/sic_pkg.sv -----
// Shared constants for the segment intersection classifier.
// No dependencies; used by every other file of the block.
package sic_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF  = 12;

  localparam int unsigned TOL_BITS = 12;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 12'd41;

  localparam int unsigned REL_BITS = 4;

  localparam logic [REL_BITS-1:0] REL_UNPLACED   = 4'd0;
  localparam logic [REL_BITS-1:0] REL_DISJOINT   = 4'd1;
  localparam logic [REL_BITS-1:0] REL_SHARED     = 4'd2;
  localparam logic [REL_BITS-1:0] REL_P1_INSIDE  = 4'd3;
  localparam logic [REL_BITS-1:0] REL_P2_INSIDE  = 4'd4;
  localparam logic [REL_BITS-1:0] REL_P3_INSIDE  = 4'd5;
  localparam logic [REL_BITS-1:0] REL_P4_INSIDE  = 4'd6;
  localparam logic [REL_BITS-1:0] REL_CROSSING   = 4'd7;
  localparam logic [REL_BITS-1:0] REL_OVERLAP    = 4'd8;
  localparam logic [REL_BITS-1:0] REL_EQUAL      = 4'd9;
  localparam logic [REL_BITS-1:0] REL_UNDECIDED  = 4'd10;

endpackage

// ----- design/segment_intersection_classifier.sv -----
// Top level of the segment intersection classifier: seven-stage pipeline.
// Depends on sic_pkg and sic_collinear.
//
// Usage: the input channel (in_valid_i / in_ready_o) carries one pair of
// segments per transfer: all_placed_i and the four endpoints in signed
// fixed point. The output channel (out_valid_o / out_ready_i) carries one
// relation code per input transfer, in order.
// Throughput is one pair per cycle while the receiver takes results: each
// of the seven stages (differences, products, determinants, tolerance
// checks, scale multiply, bound adds, final compares) holds one pair and
// every stage has its own valid bit.
// When the receiver stalls, only full stages hold; empty stages upstream
// keep filling, so in_ready_o drops only once every stage holds a pair.
// The tolerance register is written with cfg_we_i / cfg_wdata_i, with no
// wait; write it only while no pair is in flight.
// Reset empties all stages and loads the tolerance with its default (41).

module segment_intersection_classifier #(
  parameter int unsigned COORD_BITS = sic_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sic_pkg::TOL_BITS-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               all_placed_i,
  input  logic signed [COORD_BITS-1:0]       first_begin_x_i,
  input  logic signed [COORD_BITS-1:0]       first_begin_y_i,
  input  logic signed [COORD_BITS-1:0]       first_end_x_i,
  input  logic signed [COORD_BITS-1:0]       first_end_y_i,
  input  logic signed [COORD_BITS-1:0]       second_begin_x_i,
  input  logic signed [COORD_BITS-1:0]       second_begin_y_i,
  input  logic signed [COORD_BITS-1:0]       second_end_x_i,
  input  logic signed [COORD_BITS-1:0]       second_end_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sic_pkg::REL_BITS-1:0]       relation_o
);

  localparam int unsigned T    = sic_pkg::TOL_BITS;
  localparam int unsigned DW   = COORD_BITS + 1;        // coordinate differences
  localparam int unsigned PW   = 2 * DW;                // products of differences
  localparam int unsigned DETW = PW + 1;                // determinants
  localparam int unsigned NW   = DW + 2;                // collinear numerators
  localparam int unsigned DENW = DW + 1;                // collinear divisor
  localparam int unsigned HW   = T + 1 + DENW;          // tolerance times divisor
  localparam int unsigned MW   = DETW + FRAC_BITS + T + 3;
  localparam int unsigned NST  = 7;

  // Tolerance register
  logic [T-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= sic_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Valid bits and per-stage advance; a stage loads when empty or draining.
  logic [NST:1] v_q;
  logic [NST+1:1] adv;
  logic [NST:1] v_in;

  always_comb begin
    adv[NST+1] = out_ready_i;
    for (int k = NST; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_in[1] = in_valid_i;
    for (int k = 2; k <= NST; k++) begin
      v_in[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (adv[k]) v_q[k] <= v_in[k];
      end
    end
  end

  assign in_ready_o  = adv[1];
  assign out_valid_o = v_q[NST];

  // Stage 1: coordinate differences
  logic                 pl1_q;
  logic signed [DW-1:0] a11_1_q, a12_1_q, a21_1_q, a22_1_q, b1_1_q, b2_1_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      pl1_q   <= all_placed_i;
      a11_1_q <= DW'(first_end_x_i) - DW'(first_begin_x_i);
      a21_1_q <= DW'(first_end_y_i) - DW'(first_begin_y_i);
      a12_1_q <= DW'(second_begin_x_i) - DW'(second_end_x_i);
      a22_1_q <= DW'(second_begin_y_i) - DW'(second_end_y_i);
      b1_1_q  <= DW'(second_begin_x_i) - DW'(first_begin_x_i);
      b2_1_q  <= DW'(second_begin_y_i) - DW'(first_begin_y_i);
    end
  end

  // Stage 2: six products; collinear operand select, sign fix and order
  logic                   pl2_q, dz2_q;
  logic signed [PW-1:0]   pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [DENW-1:0] den2_q;
  logic signed [NW-1:0]   na2_q, nb2_q;

  logic signed [DENW-1:0] tol_s, a11_e, den_r, den_n;
  logic signed [NW-1:0]   na_r, nb_r, na_n, nb_n;
  logic                   use_x;

  always_comb begin
    tol_s = DENW'({1'b0, tol_q});
    a11_e = DENW'(a11_1_q);
    use_x = (a11_e > tol_s) || (a11_e < -tol_s);
    den_r = use_x ? DENW'(a11_1_q) : DENW'(a21_1_q);
    na_r  = use_x ? NW'(b1_1_q) : NW'(b2_1_q);
    nb_r  = use_x ? NW'(b1_1_q) - NW'(a12_1_q) : NW'(b2_1_q) - NW'(a22_1_q);
    if (den_r < 0) begin
      den_n = -den_r;
      na_r  = -na_r;
      nb_r  = -nb_r;
    end else begin
      den_n = den_r;
    end
    if (nb_r < na_r) begin
      na_n = nb_r;
      nb_n = na_r;
    end else begin
      na_n = na_r;
      nb_n = nb_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      pl2_q  <= pl1_q;
      pa_q   <= PW'(a11_1_q) * PW'(a22_1_q);
      pb_q   <= PW'(a12_1_q) * PW'(a21_1_q);
      pc_q   <= PW'(a11_1_q) * PW'(b2_1_q);
      pd_q   <= PW'(a21_1_q) * PW'(b1_1_q);
      pe_q   <= PW'(b1_1_q) * PW'(a22_1_q);
      pf_q   <= PW'(b2_1_q) * PW'(a12_1_q);
      den2_q <= den_n;
      na2_q  <= na_n;
      nb2_q  <= nb_n;
      dz2_q  <= (den_r == '0);
    end
  end

  // Stage 3: determinants; collinear tolerance bound
  logic                   pl3_q, dz3_q;
  logic signed [DETW-1:0] del3_q, d1_3_q, d2_3_q;
  logic signed [DENW-1:0] den3_q;
  logic signed [NW-1:0]   na3_q, nb3_q;
  logic signed [HW-1:0]   hi3_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      pl3_q  <= pl2_q;
      del3_q <= DETW'(pa_q) - DETW'(pb_q);
      d2_3_q <= DETW'(pc_q) - DETW'(pd_q);
      d1_3_q <= DETW'(pe_q) - DETW'(pf_q);
      hi3_q  <= HW'($signed({1'b0, tol_q})) * HW'(den2_q);
      den3_q <= den2_q;
      na3_q  <= na2_q;
      nb3_q  <= nb2_q;
      dz3_q  <= dz2_q;
    end
  end

  // Stage 4: parallel test, sign fix of the determinant, collinear class
  logic [sic_pkg::REL_BITS-1:0] col_rel, col4_q;
  logic                         pl4_q, par4_q, crgt4_q, dz4_q;
  logic [DETW-1:0]              dl4_q;
  logic signed [MW-1:0]         d1n4_q, d2n4_q;
  logic signed [MW-1:0]         dlt, e2, absd, dd1, dd2, absd2;

  sic_collinear #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_collinear (
    .den_zero_i (dz3_q),
    .den_i      (den3_q),
    .na_i       (na3_q),
    .nb_i       (nb3_q),
    .hi_i       (hi3_q),
    .rel_o      (col_rel)
  );

  always_comb begin
    dlt   = MW'(del3_q);
    dd1   = MW'(d1_3_q);
    dd2   = MW'(d2_3_q);
    e2    = MW'(tol_q) <<< FRAC_BITS;
    absd  = (dlt < 0) ? -dlt : dlt;
    absd2 = (dd2 < 0) ? -dd2 : dd2;       // cross term of the parallel test is -d2
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      pl4_q   <= pl3_q;
      col4_q  <= col_rel;
      par4_q  <= absd < e2;
      crgt4_q <= absd2 > e2;
      dz4_q   <= (del3_q == '0);
      dl4_q   <= absd[DETW-1:0];
      d1n4_q  <= (dlt < 0) ? -dd1 : dd1;
      d2n4_q  <= (dlt < 0) ? -dd2 : dd2;
    end
  end

  // Stage 5: delta times tolerance; early decisions
  logic                         done5_q;
  logic [sic_pkg::REL_BITS-1:0] pre5_q, pre_rel;
  logic                         pre_done;
  logic [DETW+T-1:0]            lp_prod;
  logic signed [MW-1:0]         lp5_q, one5_q, x5_q, y5_q;

  always_comb begin
    lp_prod  = dl4_q * tol_q;
    pre_done = 1'b1;
    if (!pl4_q) begin
      pre_rel = sic_pkg::REL_UNPLACED;
    end else if (par4_q) begin
      pre_rel = crgt4_q ? sic_pkg::REL_DISJOINT : col4_q;
    end else if (dz4_q) begin
      pre_rel = sic_pkg::REL_UNDECIDED;
    end else begin
      pre_rel  = sic_pkg::REL_UNDECIDED;
      pre_done = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      done5_q <= pre_done;
      pre5_q  <= pre_rel;
      lp5_q   <= MW'(lp_prod);
      one5_q  <= MW'(dl4_q) <<< FRAC_BITS;
      x5_q    <= d1n4_q <<< FRAC_BITS;
      y5_q    <= d2n4_q <<< FRAC_BITS;
    end
  end

  // Stage 6: band edges around one
  logic                         done6_q;
  logic [sic_pkg::REL_BITS-1:0] pre6_q;
  logic signed [MW-1:0]         lp6_q, hm6_q, hp6_q, x6_q, y6_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      done6_q <= done5_q;
      pre6_q  <= pre5_q;
      lp6_q   <= lp5_q;
      hm6_q   <= one5_q - lp5_q;
      hp6_q   <= one5_q + lp5_q;
      x6_q    <= x5_q;
      y6_q    <= y5_q;
    end
  end

  // Stage 7: compare t and s against their bands; output register
  logic [sic_pkg::REL_BITS-1:0] rel7_q, fin_rel;
  logic signed [MW-1:0]         lm;
  logic                         outside, t_in, s_in, t0, t1, s0, s1;

  always_comb begin
    lm      = -lp6_q;
    outside = (x6_q < lm) || (x6_q > hp6_q) || (y6_q < lm) || (y6_q > hp6_q);
    t_in    = (x6_q > lp6_q) && (x6_q < hm6_q);
    s_in    = (y6_q > lp6_q) && (y6_q < hm6_q);
    t0      = (x6_q > lm) && (x6_q < lp6_q);
    t1      = (x6_q > hm6_q) && (x6_q < hp6_q);
    s0      = (y6_q > lm) && (y6_q < lp6_q);
    s1      = (y6_q > hm6_q) && (y6_q < hp6_q);
    if (done6_q)                      fin_rel = pre6_q;
    else if (outside)                 fin_rel = sic_pkg::REL_DISJOINT;
    else if (t_in && s_in)            fin_rel = sic_pkg::REL_CROSSING;
    else if (t_in && s0)              fin_rel = sic_pkg::REL_P3_INSIDE;
    else if (t_in && s1)              fin_rel = sic_pkg::REL_P4_INSIDE;
    else if (s_in && t0)              fin_rel = sic_pkg::REL_P1_INSIDE;
    else if (s_in && t1)              fin_rel = sic_pkg::REL_P2_INSIDE;
    else if ((t0 || t1) && (s0 || s1)) fin_rel = sic_pkg::REL_SHARED;
    else                              fin_rel = sic_pkg::REL_UNDECIDED;
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      rel7_q <= fin_rel;
    end
  end

  assign relation_o = rel7_q;

endmodule

// ----- design/sic_collinear.sv -----
// Collinear-case classifier: projected ends of the second segment against [0,1].
// Depends on sic_pkg.
module sic_collinear #(
  parameter int unsigned COORD_BITS = sic_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = sic_pkg::FRAC_BITS_DEF,
  localparam int unsigned DW   = COORD_BITS + 1,
  localparam int unsigned NW   = DW + 2,
  localparam int unsigned DENW = DW + 1,
  localparam int unsigned HW   = sic_pkg::TOL_BITS + 1 + DENW
) (
  input  logic                          den_zero_i,
  input  logic signed [DENW-1:0]        den_i,
  input  logic signed [NW-1:0]          na_i,
  input  logic signed [NW-1:0]          nb_i,
  input  logic signed [HW-1:0]          hi_i,
  output logic [sic_pkg::REL_BITS-1:0]  rel_o
);

  localparam int unsigned CW = NW + FRAC_BITS + sic_pkg::TOL_BITS + 4;

  logic signed [CW-1:0] one_den, hi, lo, m1, p1, a, b;

  always_comb begin
    one_den = CW'(den_i) <<< FRAC_BITS;
    hi      = CW'(hi_i);
    lo      = -hi;
    m1      = one_den - hi;
    p1      = one_den + hi;
    a       = CW'(na_i) <<< FRAC_BITS;
    b       = CW'(nb_i) <<< FRAC_BITS;
    if (den_zero_i) begin
      rel_o = sic_pkg::REL_UNDECIDED;
    end else if (a <= lo) begin
      if (b <= lo)      rel_o = sic_pkg::REL_DISJOINT;
      else if (b <= hi) rel_o = sic_pkg::REL_SHARED;
      else              rel_o = sic_pkg::REL_OVERLAP;
    end else if (a <= hi) begin
      rel_o = (b >= m1 && b <= p1) ? sic_pkg::REL_EQUAL : sic_pkg::REL_OVERLAP;
    end else if (a <= m1) begin
      rel_o = sic_pkg::REL_OVERLAP;
    end else if (a <= p1) begin
      rel_o = sic_pkg::REL_SHARED;
    end else begin
      rel_o = sic_pkg::REL_DISJOINT;
    end
  end

endmodule

// ----- design/sic_checker.sv -----
// Port-level checks for the segment intersection classifier, bound to its top.
// Depends on sic_pkg.
module sic_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [sic_pkg::REL_BITS-1:0]      relation_o
);

  // A held result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A draining output frees every stage, so input is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output drains");

  // An empty output stage leaves room upstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // Only defined relation codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> relation_o <= sic_pkg::REL_UNDECIDED)
    else $error("relation code out of range");

endmodule

bind segment_intersection_classifier sic_checker u_sic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .relation_o  (relation_o)
);

// ----- bench/segment_intersection_classifier_tb.sv -----
// Self-checking bench for segment_intersection_classifier: streams segment pairs,
// predicts each relation class with exact wide integer arithmetic and compares in order.
// Depends on sic_pkg and the classifier RTL.
`timescale 1ns / 100ps

module segment_intersection_classifier_tb;

  localparam int CW = 24;
  localparam int FB = 12;
  localparam int PIPE_DEPTH = 7;
  localparam longint CYCLE_LIMIT = 600000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [127:0]  wide_t;
  typedef logic [sic_pkg::REL_BITS-1:0] rel_t;
  typedef logic [sic_pkg::TOL_BITS-1:0] tol_t;

  typedef struct {
    logic   placed;
    coord_t c[8];
  } pair_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  tol_t cfg_wdata_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic all_placed_i = 0;
  coord_t fbx = '0, fby = '0, fex = '0, fey = '0;
  coord_t sbx = '0, sby = '0, sex = '0, sey = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  rel_t relation_o;

  segment_intersection_classifier dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .all_placed_i(all_placed_i),
    .first_begin_x_i(fbx), .first_begin_y_i(fby),
    .first_end_x_i(fex), .first_end_y_i(fey),
    .second_begin_x_i(sbx), .second_begin_y_i(sby),
    .second_end_x_i(sex), .second_end_y_i(sey),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .relation_o(relation_o)
  );

  initial forever #5 clk_i = ~clk_i;

  // Bench state: predictor copy of the tolerance, expected relation queue, tallies.
  tol_t tol_shadow = sic_pkg::TOL_RESET;
  rel_t relation_q[$];
  int  mismatch_cnt = 0;
  int  orphan_cnt = 0;
  int  sent_cnt = 0;
  int  rel_seen[16];
  longint cycle_cnt = 0;
  bit  long_stalls = 0;

  // Collinear branch: project onto x, or onto y when the x extent is within tolerance.
  function automatic rel_t collinear_rel(longint a11, longint a12, longint a21,
                                         longint a22, longint b1, longint b2,
                                         longint tol);
    longint one, den, na, nb, tmp, lo, hi, m1, p1, a, b;
    one = longint'(1) << FB;
    if ((a11 < 0 ? -a11 : a11) > tol) begin
      den = a11; na = b1; nb = b1 - a12;
    end else begin
      den = a21; na = b2; nb = b2 - a22;
    end
    if (den == 0) return sic_pkg::REL_UNDECIDED;
    if (den < 0) begin
      den = -den; na = -na; nb = -nb;
    end
    if (nb < na) begin
      tmp = na; na = nb; nb = tmp;
    end
    hi = tol * den;
    lo = -hi;
    m1 = (one - tol) * den;
    p1 = (one + tol) * den;
    a = na * one;
    b = nb * one;
    if (a <= lo) begin
      if (b <= lo) return sic_pkg::REL_DISJOINT;
      if (b <= hi) return sic_pkg::REL_SHARED;
      return sic_pkg::REL_OVERLAP;
    end
    if (a <= hi) return (b >= m1 && b <= p1) ? sic_pkg::REL_EQUAL : sic_pkg::REL_OVERLAP;
    if (a <= m1) return sic_pkg::REL_OVERLAP;
    if (a <= p1) return sic_pkg::REL_SHARED;
    return sic_pkg::REL_DISJOINT;
  endfunction

  // Cramer's rule on t and s, every tolerance test done by cross-multiplication.
  function automatic rel_t classify_pair(pair_t p, tol_t tol_r);
    longint c[8];
    longint a11, a12, a21, a22, b1, b2, tol, one;
    wide_t dl, d1, d2, e2, cr, lm, lp, hm, hp, x, y;
    bit t_in, s_in, t0, t1, s0, s1;
    for (int i = 0; i < 8; i++) c[i] = longint'(p.c[i]);
    tol = longint'(tol_r);
    one = longint'(1) << FB;
    a11 = c[2] - c[0]; a12 = c[4] - c[6]; b1 = c[4] - c[0];
    a21 = c[3] - c[1]; a22 = c[5] - c[7]; b2 = c[5] - c[1];
    dl = wide_t'(a11) * wide_t'(a22) - wide_t'(a12) * wide_t'(a21);
    d2 = wide_t'(a11) * wide_t'(b2) - wide_t'(a21) * wide_t'(b1);
    d1 = wide_t'(b1) * wide_t'(a22) - wide_t'(b2) * wide_t'(a12);
    e2 = wide_t'(tol * one);
    if ((dl < 0 ? -dl : dl) < e2) begin
      cr = wide_t'(b1) * wide_t'(a21) - wide_t'(b2) * wide_t'(a11);
      if ((cr < 0 ? -cr : cr) > e2) return sic_pkg::REL_DISJOINT;
      return collinear_rel(a11, a12, a21, a22, b1, b2, tol);
    end
    if (dl == 0) return sic_pkg::REL_UNDECIDED;
    if (dl < 0) begin
      dl = -dl; d1 = -d1; d2 = -d2;
    end
    lm = dl * wide_t'(-tol);
    lp = dl * wide_t'(tol);
    hm = dl * wide_t'(one - tol);
    hp = dl * wide_t'(one + tol);
    x = d1 <<< FB;
    y = d2 <<< FB;
    if (x < lm || x > hp || y < lm || y > hp) return sic_pkg::REL_DISJOINT;
    t_in = x > lp && x < hm;
    s_in = y > lp && y < hm;
    t0 = x > lm && x < lp;
    t1 = x > hm && x < hp;
    s0 = y > lm && y < lp;
    s1 = y > hm && y < hp;
    if (t_in && s_in) return sic_pkg::REL_CROSSING;
    if (t_in) begin
      if (s0) return sic_pkg::REL_P3_INSIDE;
      if (s1) return sic_pkg::REL_P4_INSIDE;
    end
    if (s_in) begin
      if (t0) return sic_pkg::REL_P1_INSIDE;
      if (t1) return sic_pkg::REL_P2_INSIDE;
    end
    if ((t0 || t1) && (s0 || s1)) return sic_pkg::REL_SHARED;
    return sic_pkg::REL_UNDECIDED;
  endfunction

  function automatic int short_or_long(int long_max);
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, long_max);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  // Drive one pair, hold it until the transfer, then predict its relation.
  // Valid stays high after the transfer; an idle gap or a drain drops it.
  task automatic send_pair(pair_t p, bit gaps);
    int idle;
    idle = gaps ? short_or_long(30) : 0;
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    all_placed_i <= p.placed;
    fbx <= p.c[0]; fby <= p.c[1]; fex <= p.c[2]; fey <= p.c[3];
    sbx <= p.c[4]; sby <= p.c[5]; sex <= p.c[6]; sey <= p.c[7];
    do @(posedge clk_i); while (!in_ready_o);
    relation_q.push_back(p.placed ? classify_pair(p, tol_shadow) : sic_pkg::REL_UNPLACED);
    sent_cnt++;
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (relation_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic write_tolerance(tol_t v);
    drain_pipe();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tol_shadow = v;
  endtask

  function automatic pair_t make_pair(longint x1, longint y1, longint x2, longint y2,
                                      longint x3, longint y3, longint x4, longint y4);
    pair_t p;
    p.placed = 1'b1;
    p.c[0] = coord_t'(x1); p.c[1] = coord_t'(y1); p.c[2] = coord_t'(x2);
    p.c[3] = coord_t'(y2); p.c[4] = coord_t'(x3); p.c[5] = coord_t'(y3);
    p.c[6] = coord_t'(x4); p.c[7] = coord_t'(y4);
    return p;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return $urandom_range(0, 1) ? coord_t'(24'h7FFFFF) : coord_t'(24'h800000);
      2: return coord_t'($signed($urandom_range(0, 64)) - 32) <<< FB;
      default: return coord_t'(longint'($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  // Build mostly well-formed geometry (shared ends, touching points, collinear runs, crossings), else random ends.
  function automatic pair_t rand_pair();
    pair_t p, q;
    longint x1, y1, dx, dy, k0, k1, jit;
    for (int i = 0; i < 8; i++) p.c[i] = rand_coord();
    p.placed = ($urandom_range(0, 15) != 0);
    q = p;
    x1 = longint'($urandom_range(0, 8191)) - 4096;
    y1 = longint'($urandom_range(0, 8191)) - 4096;
    dx = longint'($urandom_range(0, 8191)) - 4096;
    dy = ($urandom_range(0, 4) == 0) ? 0 : longint'($urandom_range(0, 8191)) - 4096;
    jit = longint'($urandom_range(0, 6)) - 3;
    k0 = longint'($urandom_range(0, 24)) - 4;
    k1 = longint'($urandom_range(0, 24)) - 4;
    case ($urandom_range(0, 6))
      0: q = make_pair(x1, y1, x1 + dx, y1 + dy, x1 + jit, y1, x1 - dy, y1 + dx);
      1: q = make_pair(x1, y1, x1 + 16 * dx, y1 + 16 * dy,
                       x1 + k0 * dx + dy, y1 + k0 * dy - dx, x1 + k0 * dx - dy,
                       y1 + k0 * dy + dx);
      2, 3: q = make_pair(x1, y1, x1 + 16 * dx, y1 + 16 * dy, x1 + k0 * dx + jit,
                          y1 + k0 * dy, x1 + k1 * dx, y1 + k1 * dy + jit);
      4: q = make_pair(x1, y1, x1 + dx, y1 + dy, x1 + dx + jit, y1 + dy, x1, y1 - jit);
      5: q = make_pair(x1, y1, x1 + dx, y1 + dy, x1 + dx, y1 + dy + jit,
                       x1 + 2 * dx + dy, y1 + 2 * dy - dx);
      default: ;
    endcase
    p.c = q.c;
    return p;
  endfunction

  // Result side: random backpressure, in-order field compare.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (relation_q.size() == 0) begin
          orphan_cnt++;
          if (mismatch_cnt + orphan_cnt <= 10)
            $display("unexpected relation %0d with nothing pending", relation_o);
        end else begin
          rel_t want;
          want = relation_q.pop_front();
          rel_seen[want]++;
          if (relation_o !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt + orphan_cnt <= 10)
              $display("relation mismatch: expected %0d, got %0d", want, relation_o);
          end
        end
      end
      out_ready_i <= long_stalls ? ($urandom_range(0, 9) < 3) : ($urandom_range(0, 9) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_directed();
    pair_t p;
    p = make_pair(0, 0, 4096, 0, 0, 0, 0, 4096); p.placed = 1'b0;
    send_pair(p, 1'b0);
    send_pair(make_pair(0, 0, 4096, 4096, 0, 4096, 4096, 0), 1'b0);       // crossing
    send_pair(make_pair(0, 0, 4096, 0, 0, 4096, 4096, 4096), 1'b0);       // parallel apart
    send_pair(make_pair(0, 0, 4096, 0, 4096, 0, 4096, 4096), 1'b0);       // shared end
    send_pair(make_pair(2048, 0, 2048, 4096, 0, 0, 4096, 0), 1'b0);       // P1 inside
    send_pair(make_pair(2048, 4096, 2048, 0, 0, 0, 4096, 0), 1'b0);       // P2 inside
    send_pair(make_pair(0, 0, 4096, 0, 2048, 0, 2048, 4096), 1'b0);       // P3 inside
    send_pair(make_pair(0, 0, 4096, 0, 2048, 4096, 2048, 0), 1'b0);       // P4 inside
    send_pair(make_pair(0, 0, 8192, 0, 4096, 0, 12288, 0), 1'b0);         // overlap
    send_pair(make_pair(0, 0, 8192, 0, 0, 0, 8192, 0), 1'b0);             // equal
    send_pair(make_pair(0, 0, 8192, 0, 12288, 0, 16384, 0), 1'b0);        // collinear apart
    send_pair(make_pair(0, 0, 0, 8192, 0, 2048, 0, 4096), 1'b0);          // y projection
    send_pair(make_pair(5, 5, 5, 5, 5, 5, 5, 5), 1'b0);                   // zero divisor
    send_pair(make_pair(0, 0, 8192, 0, 20000, 1, 30000, 1), 1'b0);        // collinear within tol
    send_pair(make_pair(-8388608, -8388608, 8388607, 8388607,
                        -8388608, 8388607, 8388607, -8388608), 1'b0);     // extreme crossing
    send_pair(make_pair(8388607, 8388607, -8388608, -8388608,
                        8388607, 8388607, 8388607, 8388607), 1'b0);
    send_pair(make_pair(-1, -1, -1, -1, 0, 0, 0, 0), 1'b0);
    drain_pipe();
  endtask

  // Tolerance zero turns off the parallel test, so a zero determinant is reported as undecided.
  task automatic test_tolerance_zero();
    write_tolerance('0);
    send_pair(make_pair(0, 0, 4096, 0, 0, 4096, 4096, 4096), 1'b1);
    send_pair(make_pair(0, 0, 4096, 0, 0, 0, 4096, 0), 1'b1);
    send_pair(make_pair(0, 0, 4096, 4096, 0, 4096, 4096, 0), 1'b1);
    for (int i = 0; i < 150; i++) send_pair(rand_pair(), 1'b1);
  endtask

  task automatic test_tolerance_max();
    write_tolerance('1);
    for (int i = 0; i < 150; i++) send_pair(rand_pair(), 1'b1);
  endtask

  // Bulk random at several settings, back-to-back bursts included.
  task automatic test_random_sweep();
    tol_t tols[4];
    tols = '{sic_pkg::TOL_RESET, 12'd1, 12'd400, 12'd2048};
    foreach (tols[k]) begin
      write_tolerance(tols[k]);
      long_stalls = (k == 2);
      for (int i = 0; i < 330; i++) send_pair(rand_pair(), (i % 100) > 30);
      if (k == 1) begin
        // Hold off the sender until every pending relation has come back.
        drain_pipe();
      end
    end
    long_stalls = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tolerance_zero();
    test_tolerance_max();
    test_random_sweep();
    drain_pipe();
    $display("sent %0d pairs over tolerances 0..4095; crossing %0d shared %0d overlap %0d",
             sent_cnt, rel_seen[sic_pkg::REL_CROSSING], rel_seen[sic_pkg::REL_SHARED],
             rel_seen[sic_pkg::REL_OVERLAP]);
    $display("equal %0d inside %0d undecided %0d disjoint %0d", rel_seen[sic_pkg::REL_EQUAL],
             rel_seen[sic_pkg::REL_P1_INSIDE] + rel_seen[sic_pkg::REL_P2_INSIDE]
             + rel_seen[sic_pkg::REL_P3_INSIDE] + rel_seen[sic_pkg::REL_P4_INSIDE],
             rel_seen[sic_pkg::REL_UNDECIDED], rel_seen[sic_pkg::REL_DISJOINT]);
    if (mismatch_cnt == 0 && orphan_cnt == 0 && relation_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d unexpected", mismatch_cnt, orphan_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
